FILE: src/dds_pkg.sv
// shared types, constants and the arctangent table for the steering pipeline
package dds_pkg;

   // default parameter values
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int DATA_WIDTH_DEF = 16;

   // datapath widths inside the cordic chains
   localparam int XY_W = 27;
   localparam int Z_W = 21;

   // angles are Q.16 radians
   localparam logic signed [Z_W-1:0] ANG_PI = 21'sd205887;
   localparam logic signed [Z_W+1:0] ANG_TWO_PI = 23'sd411775;
   localparam logic signed [Z_W-1:0] HALF_PI = 21'sd102944;
   localparam logic [15:0] INV_GAIN = 16'd39797;

   // register map
   localparam logic REG_SPEED_GAIN = 1'b0;
   localparam logic REG_TURN_GAIN = 1'b1;
   localparam logic [15:0] GAIN_RESET = 16'd256;

   typedef enum logic {
      MODE_VECTOR,
      MODE_ROTATE
   } cordic_mode_type;

   typedef struct packed {
      logic                  valid;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_sample_type;

   // round(atan(2^-i) * 2^16), zero past the table
   function automatic logic signed [Z_W-1:0] atan_at(input int idx);
      int v;
      case (idx)
         0: v = 51472;
         1: v = 30386;
         2: v = 16055;
         3: v = 8150;
         4: v = 4091;
         5: v = 2047;
         6: v = 1024;
         7: v = 512;
         8: v = 256;
         9: v = 128;
         10: v = 64;
         11: v = 32;
         12: v = 16;
         13: v = 8;
         14: v = 4;
         15: v = 2;
         16: v = 1;
         default: v = 0;
      endcase
      return Z_W'(v);
   endfunction

endpackage

FILE: src/dds_cell.sv
// one cordic micro-rotation stage, registered
module dds_cell #(
   parameter int SHIFT = 0,
   parameter dds_pkg::cordic_mode_type MODE = dds_pkg::MODE_VECTOR
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dds_pkg::cordic_sample_type d_in,
   output dds_pkg::cordic_sample_type d_out
);

   localparam logic signed [dds_pkg::Z_W-1:0] ATAN = dds_pkg::atan_at(SHIFT);

   dds_pkg::cordic_sample_type stage_ff, stage_in;
   logic signed [dds_pkg::XY_W-1:0] dx, dy;
   logic up;

   always_comb begin
      dx = d_in.y >>> SHIFT;
      dy = d_in.x >>> SHIFT;
      // vectoring drives y to zero, rotation drives z to zero
      up = (MODE == dds_pkg::MODE_VECTOR) ? !d_in.y[dds_pkg::XY_W-1]
                                          : !d_in.z[dds_pkg::Z_W-1];
      stage_in.valid = d_in.valid;
      if (MODE == dds_pkg::MODE_VECTOR) begin
         if (up) begin
            stage_in.x = d_in.x + dx;
            stage_in.y = d_in.y - dy;
            stage_in.z = d_in.z + ATAN;
         end else begin
            stage_in.x = d_in.x - dx;
            stage_in.y = d_in.y + dy;
            stage_in.z = d_in.z - ATAN;
         end
      end else begin
         if (up) begin
            stage_in.x = d_in.x - dx;
            stage_in.y = d_in.y + dy;
            stage_in.z = d_in.z - ATAN;
         end else begin
            stage_in.x = d_in.x + dx;
            stage_in.y = d_in.y - dy;
            stage_in.z = d_in.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.x <= stage_in.x;
      stage_ff.y <= stage_in.y;
      stage_ff.z <= stage_in.z;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   assign d_out = stage_ff;

endmodule

FILE: src/dds_delay.sv
// fixed-length shift line for side data that rides along a cordic chain
module dds_delay #(
   parameter int W = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] d_out
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign d_out = tap_ff[DEPTH-1];

endmodule

FILE: src/differential_drive_steering.sv
// Steering pipeline: one command per clock, busy stays low outside reset, and each result
// appears on rsp_* with rsp_valid for one cycle. The result passes through the two chains of
// cordic stages (vectoring, then sine/cosine rotation) plus seven registers around them for
// the input scaling, the gain multiplies and the wheel sums. The receiver cannot stall, so
// results must be taken as they come.
module differential_drive_steering #(
   parameter int CORDIC_STAGES = dds_pkg::CORDIC_STAGES_DEF,
   parameter int DATA_WIDTH = dds_pkg::DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [14:0] req_robot_heading,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic               rsp_saturated,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int XW = dds_pkg::XY_W;
   localparam int ZW = dds_pkg::Z_W;
   localparam int LATENCY = 2 * CORDIC_STAGES + 6;
   localparam logic signed [50:0] OUT_MAX = (51'sd1 <<< (DATA_WIDTH - 1)) - 51'sd1;
   localparam logic signed [50:0] OUT_MIN = -OUT_MAX - 51'sd1;

   // configuration registers
   logic [15:0] speed_gain_ff, turn_gain_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff <= dds_pkg::GAIN_RESET;
         turn_gain_ff <= dds_pkg::GAIN_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            dds_pkg::REG_SPEED_GAIN: speed_gain_ff <= csr_pwdata[15:0];
            dds_pkg::REG_TURN_GAIN: turn_gain_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         dds_pkg::REG_SPEED_GAIN: csr_prdata = {16'd0, speed_gain_ff};
         dds_pkg::REG_TURN_GAIN: csr_prdata = {16'd0, turn_gain_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign busy = reset;

   // input stage: scale to Q.8 and fold the left half-plane by pi
   dds_pkg::cordic_sample_type vec_ff, vec_in;
   logic signed [ZW-1:0] head_ff, head_in;
   logic signed [XW-1:0] sx, sy;

   always_comb begin
      sx = {{3{req_target_x[15]}}, req_target_x, 8'd0};
      sy = {{3{req_target_y[15]}}, req_target_y, 8'd0};
      head_in = {{2{req_robot_heading[14]}}, req_robot_heading, 4'd0};
      vec_in.valid = start && !busy;
      if (sx[XW-1]) begin
         vec_in.x = -sx;
         vec_in.y = -sy;
         vec_in.z = sy[XW-1] ? -dds_pkg::ANG_PI : dds_pkg::ANG_PI;
      end else begin
         vec_in.x = sx;
         vec_in.y = sy;
         vec_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff.x <= vec_in.x;
      vec_ff.y <= vec_in.y;
      vec_ff.z <= vec_in.z;
      head_ff <= head_in;
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else begin
         vec_ff.valid <= vec_in.valid;
      end
   end

   // vectoring chain
   dds_pkg::cordic_sample_type vchain [CORDIC_STAGES+1];
   assign vchain[0] = vec_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      dds_cell #(.SHIFT(g), .MODE(dds_pkg::MODE_VECTOR)) u_cell (
         .clock(clock),
         .reset(reset),
         .d_in (vchain[g]),
         .d_out(vchain[g+1])
      );
   end

   logic signed [ZW-1:0] head_d;
   dds_delay #(.W(ZW), .DEPTH(CORDIC_STAGES)) u_head_dly (
      .clock(clock),
      .d_in (head_ff),
      .d_out(head_d)
   );

   // stage a: magnitude product and wrapped heading error
   logic                 a_valid_ff;
   logic signed [43:0]   mprod_ff;
   logic signed [ZW-1:0] err_ff, err_in;
   logic signed [ZW+1:0] e_raw;

   always_comb begin
      e_raw = 23'(vchain[CORDIC_STAGES].z) - 23'(head_d);
      if (e_raw >= 23'(dds_pkg::ANG_PI)) begin
         err_in = ZW'(e_raw - dds_pkg::ANG_TWO_PI);
      end else if (e_raw < -23'(dds_pkg::ANG_PI)) begin
         err_in = ZW'(e_raw + dds_pkg::ANG_TWO_PI);
      end else begin
         err_in = ZW'(e_raw);
      end
   end

   always_ff @(posedge clock) begin
      mprod_ff <= 44'(vchain[CORDIC_STAGES].x) * 44'($signed({1'b0, dds_pkg::INV_GAIN}));
      err_ff <= err_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= vchain[CORDIC_STAGES].valid;
      end
   end

   // stage b: speed product, reduce error to the right half-plane
   dds_pkg::cordic_sample_type rot_ff, rot_in;
   logic signed [44:0] velp_ff;
   logic               neg_ff, neg_in, swap_ff;
   logic signed [27:0] mag;

   always_comb begin
      mag = mprod_ff[43:16];
      rot_in.valid = a_valid_ff;
      rot_in.x = XW'(dds_pkg::INV_GAIN);
      rot_in.y = '0;
      neg_in = 1'b1;
      if (err_ff > dds_pkg::HALF_PI) begin
         rot_in.z = err_ff - dds_pkg::ANG_PI;
      end else if (err_ff < -dds_pkg::HALF_PI) begin
         rot_in.z = err_ff + dds_pkg::ANG_PI;
      end else begin
         rot_in.z = err_ff;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff.x <= rot_in.x;
      rot_ff.y <= rot_in.y;
      rot_ff.z <= rot_in.z;
      velp_ff <= 45'(mag) * 45'($signed({1'b0, speed_gain_ff}));
      neg_ff <= neg_in;
      // at exactly plus or minus half pi the swapped sign applies
      swap_ff <= (err_ff >= dds_pkg::HALF_PI) || (err_ff <= -dds_pkg::HALF_PI);
      if (reset) begin
         rot_ff.valid <= 1'b0;
      end else begin
         rot_ff.valid <= rot_in.valid;
      end
   end

   // rotation chain for cos and sin
   dds_pkg::cordic_sample_type rchain [CORDIC_STAGES+1];
   assign rchain[0] = rot_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      dds_cell #(.SHIFT(g), .MODE(dds_pkg::MODE_ROTATE)) u_cell (
         .clock(clock),
         .reset(reset),
         .d_in (rchain[g]),
         .d_out(rchain[g+1])
      );
   end

   logic [46:0] side_d;
   dds_delay #(.W(47), .DEPTH(CORDIC_STAGES)) u_side_dly (
      .clock(clock),
      .d_in ({velp_ff, neg_ff, swap_ff}),
      .d_out(side_d)
   );

   // stage r: velocity and signed cos / sin
   logic                  r_valid_ff, r_swap_ff;
   logic signed [28:0]    vel_ff;
   logic signed [XW-1:0]  cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      vel_ff <= $signed(side_d[46:18]);
      cos_ff <= side_d[1] ? -rchain[CORDIC_STAGES].x : rchain[CORDIC_STAGES].x;
      sin_ff <= side_d[1] ? -rchain[CORDIC_STAGES].y : rchain[CORDIC_STAGES].y;
      r_swap_ff <= side_d[0];
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= rchain[CORDIC_STAGES].valid;
      end
   end

   // stage d: velocity times cos and sin
   logic               d_valid_ff, d_swap_ff;
   logic signed [55:0] fwdp_ff, sinp_ff;

   always_ff @(posedge clock) begin
      fwdp_ff <= 56'(vel_ff) * 56'(cos_ff);
      sinp_ff <= 56'(vel_ff) * 56'(sin_ff);
      d_swap_ff <= r_swap_ff;
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= r_valid_ff;
      end
   end

   // stage e: turn gain split into high and low partial products
   logic               e_valid_ff, e_swap_ff;
   logic signed [39:0] fwd_ff;
   logic signed [48:0] thi_ff;
   logic [39:0]        tlo_ff;

   always_ff @(posedge clock) begin
      fwd_ff <= fwdp_ff[55:16];
      thi_ff <= 49'($signed(sinp_ff[55:24])) * 49'($signed({1'b0, turn_gain_ff}));
      tlo_ff <= 40'(sinp_ff[23:0]) * 40'(turn_gain_ff);
      e_swap_ff <= d_swap_ff;
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
   end

   // stage f: wheel sums and saturation
   logic signed [50:0] turn, lsum, rsum;
   logic signed [15:0] left_in, right_in;
   logic               sat_in;
   logic               out_valid_ff, out_sat_ff;
   logic signed [15:0] out_left_ff, out_right_ff;

   always_comb begin
      turn = 51'(thi_ff) + 51'($signed({1'b0, tlo_ff[39:24]}));
      if (e_swap_ff) begin
         lsum = 51'(fwd_ff) + turn;
         rsum = 51'(fwd_ff) - turn;
      end else begin
         lsum = 51'(fwd_ff) - turn;
         rsum = 51'(fwd_ff) + turn;
      end
      sat_in = 1'b0;
      if (lsum > OUT_MAX) begin
         left_in = OUT_MAX[15:0];
         sat_in = 1'b1;
      end else if (lsum < OUT_MIN) begin
         left_in = OUT_MIN[15:0];
         sat_in = 1'b1;
      end else begin
         left_in = lsum[15:0];
      end
      if (rsum > OUT_MAX) begin
         right_in = OUT_MAX[15:0];
         sat_in = 1'b1;
      end else if (rsum < OUT_MIN) begin
         right_in = OUT_MIN[15:0];
         sat_in = 1'b1;
      end else begin
         right_in = rsum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      out_left_ff <= left_in;
      out_right_ff <= right_in;
      out_sat_ff <= sat_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= e_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_left_speed = out_left_ff;
   assign rsp_right_speed = out_right_ff;
   assign rsp_saturated = out_sat_ff;

   // every accepted transfer comes out as a result with rsp_valid after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LATENCY + 1) rsp_valid)
      else $error("result missing after fixed latency");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == dds_pkg::REG_SPEED_GAIN)
      |=> speed_gain_ff == $past(csr_pwdata[15:0]))
      else $error("speed gain write lost");

endmodule
